### rtl/lru_channel_allocator_with_steal_core_defines.svh
// ----------------------------------------------------------------------------
// LRU channel allocator assertion macros
// Shared concurrent-check shorthands, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_CHANNEL_ALLOCATOR_WITH_STEAL_CORE_DEFINES_SVH
`define LRU_CHANNEL_ALLOCATOR_WITH_STEAL_CORE_DEFINES_SVH

// Same-cycle implication.
`define LCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lca check failed");

// Next-cycle implication.
`define LCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lca check failed");

`endif

### rtl/lca_pkg.sv
// ----------------------------------------------------------------------------
// LRU channel allocator package
// Register indexes, fixed widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int CFG_W = 5;   // configuration data width
    localparam int CH_W  = 5;   // MIDI channel field width

    localparam logic CFG_FIRST_CHANNEL = 1'b0;
    localparam logic CFG_CHANNEL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] FIRST_CHANNEL_RST = 5'd2;
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = 5'd15;

    localparam logic MODE_CLEAR = 1'b1;

    // Update command for one channel cell.
    typedef struct packed {
        logic clr;  // free the channel
        logic wr;   // place the current note on the channel
    } t_cell_ctl;

endpackage

### rtl/lca_cell.sv
// ----------------------------------------------------------------------------
// LRU channel allocator cell
// Holds one channel's state and refines the traveling best candidate.
// ----------------------------------------------------------------------------
module lca_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = 32,
    parameter int ID_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lca_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_active,
    input  logic [TIME_BITS-1:0]  i_wr_end,
    input  logic [TIME_BITS-1:0]  i_wr_start,
    input  logic [ID_BITS-1:0]    i_wr_id,
    input  logic                  i_tok,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [TIME_BITS-1:0]  i_ft,
    input  logic [ID_BITS-1:0]    i_note,
    input  logic [TIME_BITS-1:0]  i_ostart,
    output logic                  o_tok,
    output logic [IDX_W-1:0]      o_idx,
    output logic [TIME_BITS-1:0]  o_ft,
    output logic [ID_BITS-1:0]    o_note,
    output logic [TIME_BITS-1:0]  o_ostart
);
    import lca_pkg::*;

    logic [TIME_BITS-1:0] r_ft;
    logic [ID_BITS-1:0]   r_note;
    logic [TIME_BITS-1:0] r_start;
    logic                 r_tok;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_cft;
    logic [ID_BITS-1:0]   r_cnote;
    logic [TIME_BITS-1:0] r_cstart;
    logic                 w_take;

    // Strictly lower free time wins, so ties stay with the lower index.
    assign w_take = (INDEX == 0) || (i_active && (r_ft < i_ft));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ft    <= '0;
            r_note  <= '0;
            r_start <= '0;
        end else if (i_ctl.clr) begin
            r_ft <= '0;
        end else if (i_ctl.wr) begin
            r_ft    <= i_wr_end;
            r_note  <= i_wr_id;
            r_start <= i_wr_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Hold the candidate once the token has passed.
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_idx    <= w_take ? IDX_W'(INDEX) : i_idx;
            r_cft    <= w_take ? r_ft : i_ft;
            r_cnote  <= w_take ? r_note : i_note;
            r_cstart <= w_take ? r_start : i_ostart;
        end
    end

    assign o_tok    = r_tok;
    assign o_idx    = r_idx;
    assign o_ft     = r_cft;
    assign o_note   = r_cnote;
    assign o_ostart = r_cstart;

endmodule

### rtl/lru_channel_allocator_with_steal_core.sv
// ----------------------------------------------------------------------------
// LRU channel allocator with stealing
// Places notes on the least recently freed member channel, stealing if full.
// ----------------------------------------------------------------------------
// One note at a time: an allocate beat loads the result register once its
// search ends, and the input is ready again in that same clock, so a new
// note is taken only after the previous search has finished.
// The search runs along the chain of channel cells: a search token carrying
// the best candidate so far (lowest free time, lowest index on ties) moves
// one cell per clock. A clear beat frees every channel and loads an all-zero
// result, and the input is ready again as that result is loaded. A new note
// is accepted while the previous result still waits in the output register;
// its search then holds at the end until that beat leaves.
// Configuration writes land at once and must only be issued while the block
// is idle.
// ----------------------------------------------------------------------------
`include "lru_channel_allocator_with_steal_core_defines.svh"

module lru_channel_allocator_with_steal_core #(
    parameter int MAX_CHANNELS = 16,
    parameter int TIME_BITS    = 32,
    parameter int ID_BITS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [lca_pkg::CFG_W-1:0]   i_cfg_data,
    // input beat
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [TIME_BITS-1:0]        i_note_start,
    input  logic [TIME_BITS-1:0]        i_note_end,
    input  logic [ID_BITS-1:0]          i_note_id,
    // result beat
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lca_pkg::CH_W-1:0]    o_channel,
    output logic                        o_stolen,
    output logic [ID_BITS-1:0]          o_victim_id,
    output logic [TIME_BITS-1:0]        o_victim_length
);
    import lca_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CFG_W-1:0]     r_first;
    logic [CFG_W-1:0]     r_count;
    logic                 r_mode;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_end;
    logic [ID_BITS-1:0]   r_id;

    logic                 r_out_valid;
    logic [CH_W-1:0]      r_channel;
    logic                 r_stolen;
    logic [ID_BITS-1:0]   r_victim_id;
    logic [TIME_BITS-1:0] r_victim_len;

    logic                 w_in_acc;
    logic                 w_launch;
    logic                 w_fin_go;
    logic                 w_steal;
    logic [TIME_BITS-1:0] w_vlen;

    // Chain taps, one per cell output.
    logic                 w_tok    [MAX_CHANNELS];
    logic [IDX_W-1:0]     w_idx    [MAX_CHANNELS];
    logic [TIME_BITS-1:0] w_ft     [MAX_CHANNELS];
    logic [ID_BITS-1:0]   w_note   [MAX_CHANNELS];
    logic [TIME_BITS-1:0] w_ostart [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] w_tok_vec;
    t_cell_ctl            w_ctl    [MAX_CHANNELS];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_launch   = w_in_acc && (i_mode != MODE_CLEAR);
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_CHANNEL_RST;
            r_count <= CHANNEL_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_CHANNEL: r_first <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_mode == MODE_CLEAR) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                // token has left the last cell: best candidate is final
                if (w_tok[MAX_CHANNELS-1]) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the note for the whole search.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_start <= i_note_start;
            r_end   <= i_note_end;
            r_id    <= i_note_id;
        end
    end

    // ---- cell chain ----
    genvar k;
    generate
        for (k = 0; k < MAX_CHANNELS; k++) begin : g_cell
            logic                 w_active;
            logic                 w_tok_in;
            logic [IDX_W-1:0]     w_idx_in;
            logic [TIME_BITS-1:0] w_ft_in;
            logic [ID_BITS-1:0]   w_note_in;
            logic [TIME_BITS-1:0] w_ostart_in;

            // channel_count of zero still keeps cell 0 in use
            assign w_active = (k == 0) || (32'(k) < 32'(r_count));

            if (k == 0) begin : g_seed
                assign w_tok_in    = w_launch;
                assign w_idx_in    = '0;
                assign w_ft_in     = '0;
                assign w_note_in   = '0;
                assign w_ostart_in = '0;
            end else begin : g_link
                assign w_tok_in    = w_tok[k-1];
                assign w_idx_in    = w_idx[k-1];
                assign w_ft_in     = w_ft[k-1];
                assign w_note_in   = w_note[k-1];
                assign w_ostart_in = w_ostart[k-1];
            end

            assign w_ctl[k].clr = w_fin_go && (r_mode == MODE_CLEAR);
            assign w_ctl[k].wr  = w_fin_go && (r_mode != MODE_CLEAR)
                                  && (w_idx[MAX_CHANNELS-1] == IDX_W'(k));
            assign w_tok_vec[k] = w_tok[k];

            lca_cell #(
                .INDEX     (k),
                .IDX_W     (IDX_W),
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[k]),
                .i_active   (w_active),
                .i_wr_end   (r_end),
                .i_wr_start (r_start),
                .i_wr_id    (r_id),
                .i_tok      (w_tok_in),
                .i_idx      (w_idx_in),
                .i_ft       (w_ft_in),
                .i_note     (w_note_in),
                .i_ostart   (w_ostart_in),
                .o_tok      (w_tok[k]),
                .o_idx      (w_idx[k]),
                .o_ft       (w_ft[k]),
                .o_note     (w_note[k]),
                .o_ostart   (w_ostart[k])
            );
        end
    endgenerate

    // The lowest free time overall is free whenever any channel is free,
    // so one minimum search serves both the free pick and the steal pick.
    assign w_steal = (w_ft[MAX_CHANNELS-1] > r_start);
    assign w_vlen  = (r_start >= w_ostart[MAX_CHANNELS-1])
                   ? (r_start - w_ostart[MAX_CHANNELS-1]) : '0;

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            if (r_mode == MODE_CLEAR) begin
                r_channel    <= '0;
                r_stolen     <= 1'b0;
                r_victim_id  <= '0;
                r_victim_len <= '0;
            end else begin
                // channel number wraps to 5 bits
                r_channel    <= r_first + CH_W'(w_idx[MAX_CHANNELS-1]);
                r_stolen     <= w_steal;
                r_victim_id  <= w_steal ? w_note[MAX_CHANNELS-1] : '0;
                r_victim_len <= w_steal ? w_vlen : '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel       = r_channel;
    assign o_stolen        = r_stolen;
    assign o_victim_id     = r_victim_id;
    assign o_victim_length = r_victim_len;

    // ---- checks ----
    `LCA_ASSERT_NOW(a_single_token, 1'b1, $onehot0(w_tok_vec))
    `LCA_ASSERT_NOW(a_idle_chain_empty, o_in_ready, w_tok_vec == '0)
    `LCA_ASSERT_NEXT(a_result_loaded, w_fin_go, o_out_valid && o_in_ready)

endmodule
